FILE: src/tcpoq_pkg.sv
// Shared types, widths and codes for the two-class priority order queue.
`default_nettype none
package tcpoq_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 16;

	localparam int unsigned TAG_W    = 16;
	localparam int unsigned WGT_W    = 8;
	localparam int unsigned RATE_W   = 16;
	localparam int unsigned COST_W   = 24;
	localparam int unsigned FUNC_W   = 2;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned ENTRY_W  = TAG_W + WGT_W;

	// input beat: customer_tag, is_priority, weight
	localparam int unsigned IN_BITS    = TAG_W + 1 + WGT_W;
	localparam int unsigned IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;

	localparam int unsigned APB_DATA_W = 32;
	localparam int unsigned APB_ADDR_W = 3;

	localparam logic [RATE_W-1:0] REGULAR_RATE_RST  = RATE_W'(5000);
	localparam logic [RATE_W-1:0] PRIORITY_RATE_RST = RATE_W'(8000);

	// register word index, taken from paddr[2]
	localparam logic REG_REGULAR_RATE  = 1'b0;
	localparam logic REG_PRIORITY_RATE = 1'b1;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ENQUEUE = 2'd0,
		FUNC_DEQUEUE = 2'd1,
		FUNC_CLEAR   = 2'd2
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_DONE  = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [RATE_W-1:0] regular_rate;
		logic [RATE_W-1:0] priority_rate;
	} rates_t;

endpackage
`default_nettype wire

FILE: src/tcpoq_cfg.sv
// APB register block holding the two class rates.
`default_nettype none
module tcpoq_cfg (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [tcpoq_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire logic [tcpoq_pkg::APB_DATA_W-1:0]     pwdata,
	output logic      [tcpoq_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                      pready,
	output tcpoq_pkg::rates_t                         rates
);

	logic [tcpoq_pkg::RATE_W-1:0] regular_rate_q;
	logic [tcpoq_pkg::RATE_W-1:0] priority_rate_q;
	logic                         wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regular_rate_q  <= tcpoq_pkg::REGULAR_RATE_RST;
			priority_rate_q <= tcpoq_pkg::PRIORITY_RATE_RST;
		end else if (wr_en) begin
			if (paddr[2] == tcpoq_pkg::REG_PRIORITY_RATE) begin
				priority_rate_q <= pwdata[tcpoq_pkg::RATE_W-1:0];
			end else begin
				regular_rate_q <= pwdata[tcpoq_pkg::RATE_W-1:0];
			end
		end
	end

	always_comb begin
		if (paddr[2] == tcpoq_pkg::REG_PRIORITY_RATE) begin
			prdata = tcpoq_pkg::APB_DATA_W'(priority_rate_q);
		end else begin
			prdata = tcpoq_pkg::APB_DATA_W'(regular_rate_q);
		end
	end

	assign rates.regular_rate  = regular_rate_q;
	assign rates.priority_rate = priority_rate_q;

endmodule
`default_nettype wire

FILE: src/tcpoq_mem.sv
// Entry memory: one ring per class, class bit on top of the address.
`default_nettype none
module tcpoq_mem #(
	parameter int unsigned ADDR_W = 5,
	parameter int unsigned DATA_W = 24
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [2**ADDR_W];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

FILE: src/tcpoq_ctrl.sv
// Queue control: ring pointers per class, op sequencer, cost multiply, output register.
`default_nettype none
module tcpoq_ctrl #(
	parameter int unsigned QUEUE_DEPTH = tcpoq_pkg::QUEUE_DEPTH_DEF,
	parameter int unsigned AW          = $clog2(QUEUE_DEPTH),
	parameter int unsigned CW          = $clog2(QUEUE_DEPTH + 1),
	parameter int unsigned OUT_W       = 8
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire tcpoq_pkg::rates_t                    rates,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [tcpoq_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  wire logic [tcpoq_pkg::FUNC_W-1:0]         s_tuser,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic      [OUT_W-1:0]                     m_tdata,
	output logic                                      mem_we,
	output logic      [AW:0]                          mem_waddr,
	output logic      [tcpoq_pkg::ENTRY_W-1:0]        mem_wdata,
	output logic                                      mem_re,
	output logic      [AW:0]                          mem_raddr,
	input  wire logic [tcpoq_pkg::ENTRY_W-1:0]        mem_rdata
);

	localparam int unsigned TAG_W  = tcpoq_pkg::TAG_W;
	localparam int unsigned WGT_W  = tcpoq_pkg::WGT_W;
	localparam int unsigned RATE_W = tcpoq_pkg::RATE_W;
	localparam int unsigned COST_W = tcpoq_pkg::COST_W;
	localparam logic [AW-1:0] PTR_LAST = AW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

	tcpoq_pkg::state_t state_q, state_d;

	// per-class ring pointers and counts
	logic [AW-1:0] head_p_q, head_r_q, tail_p_q, tail_r_q;
	logic [AW-1:0] head_p_d, head_r_d, tail_p_d, tail_r_d;
	logic [CW-1:0] cnt_p_q, cnt_r_q, cnt_p_d, cnt_r_d;
	logic [CW-1:0] total;

	// result being built
	tcpoq_pkg::status_t          res_status_q, acc_status;
	logic [CW-1:0]               res_occ_q;
	logic [TAG_W-1:0]            res_tag_q;
	logic [WGT_W-1:0]            res_wgt_q;
	logic                        res_pri_q;
	logic [COST_W-1:0]           res_cost_q;
	logic [RATE_W-1:0]           rate_sel_q;
	logic                        deq_cls;
	logic                        rd_pend;

	logic [OUT_W-1:0]            out_data_q;
	logic                        out_valid_q;

	logic                        in_acc, load_out;
	tcpoq_pkg::func_t            func;
	logic [TAG_W-1:0]            in_tag;
	logic                        in_pri;
	logic [WGT_W-1:0]            in_wgt;
	logic [TAG_W-1:0]            rd_tag;
	logic [WGT_W-1:0]            rd_wgt;

	assign func   = tcpoq_pkg::func_t'(s_tuser);
	assign in_tag = s_tdata[TAG_W-1:0];
	assign in_pri = s_tdata[TAG_W];
	assign in_wgt = s_tdata[TAG_W+WGT_W:TAG_W+1];
	assign rd_tag = mem_rdata[tcpoq_pkg::ENTRY_W-1:WGT_W];
	assign rd_wgt = mem_rdata[WGT_W-1:0];
	assign total  = CW'(cnt_p_q + cnt_r_q);
	assign in_acc = s_tvalid && s_tready;

	// priority ring drains first
	assign deq_cls = (cnt_p_q != '0);

	// pointer and count updates at accept
	always_comb begin
		head_p_d   = head_p_q;
		head_r_d   = head_r_q;
		tail_p_d   = tail_p_q;
		tail_r_d   = tail_r_q;
		cnt_p_d    = cnt_p_q;
		cnt_r_d    = cnt_r_q;
		acc_status = tcpoq_pkg::STATUS_DONE;
		mem_we     = 1'b0;
		mem_waddr  = {in_pri, in_pri ? tail_p_q : tail_r_q};
		mem_wdata  = {in_tag, in_wgt};
		mem_re     = 1'b0;
		mem_raddr  = {deq_cls, deq_cls ? head_p_q : head_r_q};
		rd_pend    = 1'b0;
		if (in_acc) begin
			case (func)
				tcpoq_pkg::FUNC_ENQUEUE: begin
					if (total == CNT_FULL) begin
						acc_status = tcpoq_pkg::STATUS_FULL;
					end else begin
						mem_we = 1'b1;
						if (in_pri) begin
							tail_p_d = (tail_p_q == PTR_LAST) ? '0 : tail_p_q + 1'b1;
							cnt_p_d  = cnt_p_q + 1'b1;
						end else begin
							tail_r_d = (tail_r_q == PTR_LAST) ? '0 : tail_r_q + 1'b1;
							cnt_r_d  = cnt_r_q + 1'b1;
						end
					end
				end
				tcpoq_pkg::FUNC_DEQUEUE: begin
					if (total == '0) begin
						acc_status = tcpoq_pkg::STATUS_EMPTY;
					end else begin
						mem_re  = 1'b1;
						rd_pend = 1'b1;
						if (deq_cls) begin
							head_p_d = (head_p_q == PTR_LAST) ? '0 : head_p_q + 1'b1;
							cnt_p_d  = cnt_p_q - 1'b1;
						end else begin
							head_r_d = (head_r_q == PTR_LAST) ? '0 : head_r_q + 1'b1;
							cnt_r_d  = cnt_r_q - 1'b1;
						end
					end
				end
				tcpoq_pkg::FUNC_CLEAR: begin
					head_p_d = '0;
					head_r_d = '0;
					tail_p_d = '0;
					tail_r_d = '0;
					cnt_p_d  = '0;
					cnt_r_d  = '0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_p_q <= '0;
			head_r_q <= '0;
			tail_p_q <= '0;
			tail_r_q <= '0;
			cnt_p_q  <= '0;
			cnt_r_q  <= '0;
		end else begin
			head_p_q <= head_p_d;
			head_r_q <= head_r_d;
			tail_p_q <= tail_p_d;
			tail_r_q <= tail_r_d;
			cnt_p_q  <= cnt_p_d;
			cnt_r_q  <= cnt_r_d;
		end
	end

	// sequencer
	always_comb begin
		state_d = state_q;
		case (state_q)
			tcpoq_pkg::ST_IDLE: begin
				if (in_acc) begin
					state_d = rd_pend ? tcpoq_pkg::ST_READ : tcpoq_pkg::ST_DONE;
				end
			end
			tcpoq_pkg::ST_READ: state_d = tcpoq_pkg::ST_DONE;
			tcpoq_pkg::ST_DONE: begin
				if (load_out) begin
					state_d = tcpoq_pkg::ST_IDLE;
				end
			end
			default: state_d = tcpoq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (state_q == tcpoq_pkg::ST_IDLE);
		load_out = (state_q == tcpoq_pkg::ST_DONE) && (!out_valid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcpoq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// result fields; read data arrives in the cycle after the accept
	always_ff @(posedge clk) begin
		if (in_acc) begin
			res_status_q <= acc_status;
			res_occ_q    <= CW'(cnt_p_d + cnt_r_d);
			res_tag_q    <= '0;
			res_wgt_q    <= '0;
			res_pri_q    <= rd_pend && deq_cls;
			res_cost_q   <= '0;
			rate_sel_q   <= deq_cls ? rates.priority_rate : rates.regular_rate;
		end else if (state_q == tcpoq_pkg::ST_READ) begin
			res_tag_q  <= rd_tag;
			res_wgt_q  <= rd_wgt;
			res_cost_q <= COST_W'(rate_sel_q) * COST_W'(rd_wgt);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= OUT_W'({res_occ_q, res_cost_q, res_pri_q, res_wgt_q, res_tag_q,
				res_status_q});
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
`default_nettype wire

FILE: src/two_class_priority_order_queue.sv
// Top level of the two-class priority order queue.
//
//  channel   dir   handshake                 content
//  s_*       in    tvalid/tready             tuser: func; tdata: tag, class, weight
//  m_*       out   tvalid/tready             tdata: status, tag, weight, class, cost, occupancy
//  apb       in    psel/penable, pready=1    regular_rate @0x0, priority_rate @0x4
//
// One item in flight. Enqueue, clear and unused codes go from accept to the DONE state, which
// loads the output register once it is free; dequeue passes through the READ state first, in
// which the entry memory read data is captured and multiplied weight by rate. s_tready drops
// while an item is at work and while a finished result cannot enter a full, stalled output register.
// Reset empties both class rings at once (pointers and counts only) and loads the default
// rates.
`default_nettype none
module two_class_priority_order_queue #(
	parameter int unsigned QUEUE_DEPTH = tcpoq_pkg::QUEUE_DEPTH_DEF,
	parameter int unsigned CW          = $clog2(QUEUE_DEPTH + 1),
	parameter int unsigned OUT_W       = ((tcpoq_pkg::STATUS_W + tcpoq_pkg::TAG_W
		+ tcpoq_pkg::WGT_W + 1 + tcpoq_pkg::COST_W + CW + 7) / 8) * 8
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [tcpoq_pkg::APB_ADDR_W-1:0]     paddr,
	input  wire logic [tcpoq_pkg::APB_DATA_W-1:0]     pwdata,
	output logic      [tcpoq_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                      pready,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// customer_tag, is_priority, weight, zero fill
	input  wire logic [tcpoq_pkg::IN_TDATA_W-1:0]     s_tdata,
	// func
	input  wire logic [tcpoq_pkg::FUNC_W-1:0]         s_tuser,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// status, out_tag, out_weight, out_priority, cost, occupancy, zero fill
	output logic      [OUT_W-1:0]                     m_tdata
);

	localparam int unsigned AW = $clog2(QUEUE_DEPTH);

	tcpoq_pkg::rates_t                   rates;
	logic                                mem_we, mem_re;
	logic [AW:0]                         mem_waddr, mem_raddr;
	logic [tcpoq_pkg::ENTRY_W-1:0]       mem_wdata, mem_rdata;

	tcpoq_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.rates   (rates)
	);

	tcpoq_mem #(
		.ADDR_W (AW + 1),
		.DATA_W (tcpoq_pkg::ENTRY_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	tcpoq_ctrl #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.AW          (AW),
		.CW          (CW),
		.OUT_W       (OUT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.rates     (rates),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

endmodule
`default_nettype wire

FILE: src/tcpoq_checker.sv
// Port-level checks on the queue top level, bound in.
`default_nettype none
module tcpoq_checker #(
	parameter int unsigned QUEUE_DEPTH = tcpoq_pkg::QUEUE_DEPTH_DEF,
	parameter int unsigned CW          = $clog2(QUEUE_DEPTH + 1),
	parameter int unsigned OUT_W       = ((tcpoq_pkg::STATUS_W + tcpoq_pkg::TAG_W
		+ tcpoq_pkg::WGT_W + 1 + tcpoq_pkg::COST_W + CW + 7) / 8) * 8
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             m_tvalid,
	input wire logic             m_tready,
	input wire logic [OUT_W-1:0] m_tdata
);

	localparam int unsigned TAG_LO  = tcpoq_pkg::STATUS_W;
	localparam int unsigned WGT_LO  = TAG_LO + tcpoq_pkg::TAG_W;
	localparam int unsigned PRI_LO  = WGT_LO + tcpoq_pkg::WGT_W;
	localparam int unsigned COST_LO = PRI_LO + 1;
	localparam int unsigned OCC_LO  = COST_LO + tcpoq_pkg::COST_W;

	logic [tcpoq_pkg::STATUS_W-1:0] status;
	logic [tcpoq_pkg::TAG_W-1:0]    tag;
	logic [tcpoq_pkg::WGT_W-1:0]    wgt;
	logic [tcpoq_pkg::COST_W-1:0]   cost;
	logic [CW-1:0]                  occ;

	assign status = m_tdata[tcpoq_pkg::STATUS_W-1:0];
	assign tag    = m_tdata[WGT_LO-1:TAG_LO];
	assign wgt    = m_tdata[PRI_LO-1:WGT_LO];
	assign cost   = m_tdata[OCC_LO-1:COST_LO];
	assign occ    = m_tdata[OCC_LO+CW-1:OCC_LO];

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status == tcpoq_pkg::STATUS_FULL |-> occ == CW'(QUEUE_DEPTH))
		else $error("full reject with occupancy below depth");

	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status == tcpoq_pkg::STATUS_EMPTY |-> occ == '0)
		else $error("empty report with nonzero occupancy");

	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && status != tcpoq_pkg::STATUS_DONE |-> tag == '0 && wgt == '0 && cost == '0
			&& !m_tdata[PRI_LO])
		else $error("rejected beat carries entry data");

	a_cost_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && wgt == '0 |-> cost == '0)
		else $error("nonzero cost for zero weight");

endmodule

bind two_class_priority_order_queue tcpoq_checker #(
	.QUEUE_DEPTH (QUEUE_DEPTH),
	.CW          (CW),
	.OUT_W       (OUT_W)
) u_tcpoq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire

FILE: dv/two_class_priority_order_queue_checker.sv
// Scoreboard for the two-class priority order queue: queue predictor and result compare.
module two_class_priority_order_queue_checker
	import tcpoq_pkg::*;
#(
	parameter int unsigned DEPTH = QUEUE_DEPTH_DEF,
	parameter int unsigned RES_W = 56
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic                    pready,
	input  wire logic [APB_ADDR_W-1:0]   paddr,
	input  wire logic [APB_DATA_W-1:0]   pwdata,
	input  wire logic                    s_tvalid,
	input  wire logic                    s_tready,
	// customer_tag, is_priority, weight, zero fill
	input  wire logic [IN_TDATA_W-1:0]   s_tdata,
	// func
	input  wire logic [FUNC_W-1:0]       s_tuser,
	input  wire logic                    m_tvalid,
	input  wire logic                    m_tready,
	// status, out_tag, out_weight, out_priority, cost, occupancy
	input  wire logic [RES_W-1:0]        m_tdata,
	output logic      [31:0]             pending,
	output logic      [31:0]             error_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned OCC_W = $clog2(DEPTH + 1);
	localparam int unsigned TAG_LO = STATUS_W;
	localparam int unsigned WGT_LO = TAG_LO + TAG_W;
	localparam int unsigned CLS_LO = WGT_LO + WGT_W;
	localparam int unsigned COST_LO = CLS_LO + 1;
	localparam int unsigned OCC_LO = COST_LO + COST_W;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [WGT_W-1:0] wgt;
		logic             cls;
	} queue_entry_t;

	typedef struct packed {
		status_t           status;
		logic [TAG_W-1:0]  tag;
		logic [WGT_W-1:0]  wgt;
		logic              cls;
		logic [COST_W-1:0] cost;
		logic [OCC_W-1:0]  occ;
	} dequeue_report_t;

	queue_entry_t    service_line[$];
	dequeue_report_t awaited_reports[$];
	logic [RATE_W-1:0] regular_rate;
	logic [RATE_W-1:0] priority_rate;
	int unsigned       mismatches;

	function automatic dequeue_report_t serve_request(logic [FUNC_W-1:0] op,
			logic [TAG_W-1:0] tag, logic cls, logic [WGT_W-1:0] wgt);
		dequeue_report_t rep;
		queue_entry_t    ent;
		int              slot;
		rep = '0;
		rep.status = STATUS_DONE;
		case (op)
			FUNC_ENQUEUE: begin
				if (service_line.size() >= DEPTH) begin
					rep.status = STATUS_FULL;
				end else begin
					ent = '{tag: tag, wgt: wgt, cls: cls};
					slot = service_line.size();
					// priority entries go ahead of the first regular one
					if (cls) begin
						for (int i = 0; i < service_line.size(); i++) begin
							if (!service_line[i].cls) begin
								slot = i;
								break;
							end
						end
					end
					service_line.insert(slot, ent);
				end
			end
			FUNC_DEQUEUE: begin
				if (service_line.size() == 0) begin
					rep.status = STATUS_EMPTY;
				end else begin
					ent = service_line.pop_front();
					rep.tag = ent.tag;
					rep.wgt = ent.wgt;
					rep.cls = ent.cls;
					rep.cost = COST_W'(ent.wgt) *
						COST_W'(ent.cls ? priority_rate : regular_rate);
				end
			end
			FUNC_CLEAR: service_line.delete();
			default: ;
		endcase
		rep.occ = OCC_W'(service_line.size());
		return rep;
	endfunction

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		dequeue_report_t want;
		if (!arst_n) begin
			service_line.delete();
			awaited_reports.delete();
			regular_rate = REGULAR_RATE_RST;
			priority_rate = PRIORITY_RATE_RST;
			mismatches = 0;
			pending <= '0;
			error_count <= '0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[2] == REG_REGULAR_RATE)
					regular_rate = pwdata[RATE_W-1:0];
				else
					priority_rate = pwdata[RATE_W-1:0];
			end
			if (m_tvalid && m_tready) begin
				if (awaited_reports.size() == 0) begin
					$error("unexpected result beat: %h", m_tdata);
					mismatches++;
				end else begin
					want = awaited_reports.pop_front();
					compare_field("status", want.status, m_tdata[STATUS_W-1:0]);
					compare_field("out_tag", want.tag, m_tdata[TAG_LO +: TAG_W]);
					compare_field("out_weight", want.wgt, m_tdata[WGT_LO +: WGT_W]);
					compare_field("out_priority", want.cls, m_tdata[CLS_LO]);
					compare_field("cost", want.cost, m_tdata[COST_LO +: COST_W]);
					compare_field("occupancy", want.occ, m_tdata[OCC_LO +: OCC_W]);
				end
			end
			if (s_tvalid && s_tready)
				awaited_reports.push_back(serve_request(s_tuser, s_tdata[TAG_W-1:0],
					s_tdata[TAG_W], s_tdata[TAG_W+1 +: WGT_W]));
			pending <= awaited_reports.size();
			error_count <= mismatches;
		end
	end

endmodule

FILE: dv/two_class_priority_order_queue_tb.sv
// Testbench top for the two-class priority order queue: clock, reset, stimulus and verdict.
module two_class_priority_order_queue_tb;
	import tcpoq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned RES_W = ((STATUS_W + TAG_W + WGT_W + 1 + COST_W
		+ $clog2(QUEUE_DEPTH_DEF + 1) + 7) / 8) * 8;
	localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
	localparam int unsigned SEGMENTS = 8;
	localparam int unsigned SEG_ITEMS = 203;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [APB_ADDR_W-1:0] paddr = '0;
	logic [APB_DATA_W-1:0] pwdata = '0;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic [FUNC_W-1:0]     s_tuser = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [RES_W-1:0]      m_tdata;
	logic [31:0]           pending;
	logic [31:0]           error_count;

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;

	two_class_priority_order_queue dut (.*);

	two_class_priority_order_queue_checker #(
		.DEPTH(QUEUE_DEPTH_DEF),
		.RES_W(RES_W)
	) scoreboard (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk)
		m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

	initial begin
		#2_000_000;
		$display("status: fail");
		$finish;
	end

	task automatic send_beat(logic [FUNC_W-1:0] op, logic [TAG_W-1:0] tag, logic cls,
			logic [WGT_W-1:0] wgt);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= IN_TDATA_W'({wgt, cls, tag});
		do @(posedge clk); while (!s_tready);
	endtask

	// hold off the sender until the scoreboard has nothing outstanding;
	// pending is updated with a nonblocking assignment and lags behind the last accepted beat
	task automatic drain_queue();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_rate(logic reg_sel, logic [RATE_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_sel, 2'b00};
		pwdata <= APB_DATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_random(int unsigned enq_pct);
		int unsigned pick;
		logic [FUNC_W-1:0] op;
		pick = $urandom_range(0, 99);
		if (pick < enq_pct)
			op = FUNC_ENQUEUE;
		else if (pick < 96)
			op = FUNC_DEQUEUE;
		else if (pick < 98)
			op = FUNC_CLEAR;
		else
			op = FUNC_UNUSED;
		send_beat(op, TAG_W'($urandom), 1'($urandom), WGT_W'($urandom));
	endtask

	initial begin
		logic [RATE_W-1:0] reg_rates[SEGMENTS] =
			'{16'd0, 16'd65535, 16'd65535, 16'd0, 16'd0, 16'd1, 16'd0, 16'd12345};
		logic [RATE_W-1:0] pri_rates[SEGMENTS] =
			'{16'd65535, 16'd0, 16'd65535, 16'd0, 16'd0, 16'd2, 16'd0, 16'd54321};
		int unsigned enq_pct;
		reg_rates[4] = RATE_W'($urandom);
		pri_rates[4] = RATE_W'($urandom);
		reg_rates[6] = RATE_W'($urandom);
		pri_rates[6] = RATE_W'($urandom);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pass at the reset rates
		send_beat(FUNC_DEQUEUE, 16'hFFFF, 1'b1, 8'hFF);
		send_beat(FUNC_UNUSED, 16'hFFFF, 1'b1, 8'hFF);
		send_beat(FUNC_ENQUEUE, 16'hFFFF, 1'b0, 8'hFF);
		send_beat(FUNC_ENQUEUE, 16'h0000, 1'b1, 8'h00);
		send_beat(FUNC_ENQUEUE, 16'h1234, 1'b1, 8'h01);
		send_beat(FUNC_ENQUEUE, 16'hA5A5, 1'b0, 8'h80);
		send_beat(FUNC_UNUSED, 16'h0000, 1'b0, 8'h00);
		send_beat(FUNC_DEQUEUE, 16'h0000, 1'b0, 8'h00);
		send_beat(FUNC_DEQUEUE, 16'h0000, 1'b0, 8'h00);
		for (int i = 0; i < QUEUE_DEPTH_DEF - 2; i++)
			send_beat(FUNC_ENQUEUE, TAG_W'($urandom), 1'(i), WGT_W'($urandom));
		send_beat(FUNC_ENQUEUE, 16'hBEEF, 1'b1, 8'hFF);
		send_beat(FUNC_ENQUEUE, 16'hCAFE, 1'b0, 8'hFF);
		send_beat(FUNC_DEQUEUE, 16'h0000, 1'b0, 8'h00);
		send_beat(FUNC_CLEAR, 16'hFFFF, 1'b1, 8'hFF);
		send_beat(FUNC_DEQUEUE, 16'h0000, 1'b0, 8'h00);

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			drain_queue();
			write_rate(REG_REGULAR_RATE, reg_rates[seg]);
			write_rate(REG_PRIORITY_RATE, pri_rates[seg]);
			case (seg % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
				default: begin send_idle_pct = 6; recv_stall_pct = 6; end
			endcase
			enq_pct = 50;
			for (int n = 0; n < SEG_ITEMS; n++) begin
				// shift the enqueue share so the queue swings between full and empty
				if (n % 40 == 0)
					enq_pct = $urandom_range(25, 75);
				send_random(enq_pct);
			end
		end

		drain_queue();
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
